@@ rtl/rsenc_pkg.sv @@
// Package: GF(256) arithmetic and constants for the Reed-Solomon encoder.
`timescale 1ns / 1ps
`default_nettype none
package rsenc_pkg;

	localparam int MAX_EC_CODEWORDS_DEF = 30;
	localparam int EC_COUNT_RESET       = 10;
	localparam int EC_COUNT_W           = 5;
	localparam int BYTE_W               = 8;

	// Low byte of the field polynomial x^8+x^4+x^3+x^2+1
	localparam logic [BYTE_W-1:0] GF_POLY_LO = 8'h1D;

	typedef logic [BYTE_W-1:0] gf_byte_t;

	// Multiply by alpha (x) modulo the field polynomial
	function automatic gf_byte_t gf_xtime(input gf_byte_t a);
		gf_byte_t r;
		r = {a[BYTE_W-2:0], 1'b0};
		if (a[BYTE_W-1]) begin
			r = r ^ GF_POLY_LO;
		end
		return r;
	endfunction

	// General GF(256) multiply, shift-and-add over the 8 bits of b
	function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b);
		gf_byte_t acc;
		gf_byte_t x;
		acc = '0;
		x   = a;
		for (int k = 0; k < BYTE_W; k++) begin
			if (b[k]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		return acc;
	endfunction

endpackage
`default_nettype wire

@@ rtl/rsenc_if.sv @@
// Interfaces: data input, EC output and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface rsenc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;
	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface rsenc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] ec_byte;
	logic       ec_last;
	modport source (output valid, output ec_byte, output ec_last, input ready);
	modport sink   (input valid, input ec_byte, input ec_last, output ready);
endinterface

interface rsenc_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] ec_count;
	modport source (output valid, output ec_count, input ready);
	modport sink   (input valid, input ec_count, output ready);
endinterface
`default_nettype wire

@@ rtl/reed_solomon_ec_encoder.sv @@
// Top level: systematic Reed-Solomon EC encoder over GF(256), QR code style.
//
//  channel   dir  payload              transfer when
//  data_in   in   data_byte, last      data_in.valid & data_in.ready
//  ec_out    out  ec_byte, ec_last     ec_out.valid & ec_out.ready
//  cfg       in   ec_count             cfg.valid & cfg.ready
//
// Every data byte is absorbed into the remainder in the cycle it transfers,
// using one parallel GF multiplier per remainder byte, so one byte per clock
// while data_in is ready. On a last byte the remainder moves to a drain
// register that sends n EC bytes, one per cycle while ec_out is ready; data
// bytes keep flowing meanwhile, a further last byte waits. After reset and
// each cfg transfer the generator is rebuilt, data_in and cfg not ready.
`timescale 1ns / 1ps
`default_nettype none
module reed_solomon_ec_encoder import rsenc_pkg::*; #(
	parameter int MAX_EC_CODEWORDS = MAX_EC_CODEWORDS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	rsenc_in_if.sink    data_in,
	rsenc_out_if.source ec_out,
	rsenc_cfg_if.sink   cfg
);

	localparam int CNT_W   = $clog2(MAX_EC_CODEWORDS + 1);
	localparam int N_RESET = (EC_COUNT_RESET > MAX_EC_CODEWORDS) ?
		MAX_EC_CODEWORDS : EC_COUNT_RESET;

	gf_byte_t         gen [MAX_EC_CODEWORDS];
	gf_byte_t         rem_q [MAX_EC_CODEWORDS];
	gf_byte_t         rem_ext [MAX_EC_CODEWORDS+1];
	gf_byte_t         rem_next [MAX_EC_CODEWORDS];
	gf_byte_t         drain_q [MAX_EC_CODEWORDS];
	gf_byte_t         factor;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] n_cfg;
	logic [CNT_W-1:0] drain_cnt_q;
	logic             building;
	logic             in_xfer;
	logic             out_xfer;
	logic             cfg_xfer;

	// Handshakes
	assign cfg.ready     = !building;
	assign data_in.ready = !building && (!data_in.last || drain_cnt_q == '0);
	assign in_xfer       = data_in.valid && data_in.ready;
	assign out_xfer      = ec_out.valid && ec_out.ready;
	assign cfg_xfer      = cfg.valid && cfg.ready;

	// Clamp the written count to 1 .. MAX_EC_CODEWORDS
	always_comb begin
		if (cfg.ec_count == '0) begin
			n_cfg = CNT_W'(1);
		end else if (int'(cfg.ec_count) > MAX_EC_CODEWORDS) begin
			n_cfg = CNT_W'(MAX_EC_CODEWORDS);
		end else begin
			n_cfg = CNT_W'(cfg.ec_count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CNT_W'(N_RESET);
		end else if (cfg_xfer) begin
			n_q <= n_cfg;
		end
	end

	rsenc_gen_builder #(
		.MAX_EC_CODEWORDS (MAX_EC_CODEWORDS),
		.CNT_W            (CNT_W)
	) u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_xfer),
		.n      (n_q),
		.gen    (gen),
		.busy   (building)
	);

	// Division LFSR step; entries above the degree stay zero on their own
	always_comb begin
		factor = data_in.data_byte ^ rem_q[0];
		for (int k = 0; k < MAX_EC_CODEWORDS; k++) begin
			rem_ext[k] = rem_q[k];
		end
		rem_ext[MAX_EC_CODEWORDS] = '0;
		for (int k = 0; k < MAX_EC_CODEWORDS; k++) begin
			rem_next[k] = rem_ext[k+1] ^ gf_mul(factor, gen[k]);
		end
	end

	// Remainder register: cleared on config and at the end of each block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_EC_CODEWORDS; k++) begin
				rem_q[k] <= '0;
			end
		end else if (cfg_xfer || (in_xfer && data_in.last)) begin
			for (int k = 0; k < MAX_EC_CODEWORDS; k++) begin
				rem_q[k] <= '0;
			end
		end else if (in_xfer) begin
			rem_q <= rem_next;
		end
	end

	// Drain register: loaded on a last byte, shifts one EC byte out per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_cnt_q <= '0;
		end else if (in_xfer && data_in.last) begin
			drain_cnt_q <= n_q;
		end else if (out_xfer) begin
			drain_cnt_q <= drain_cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && data_in.last) begin
			drain_q <= rem_next;
		end else if (out_xfer) begin
			for (int k = 0; k < MAX_EC_CODEWORDS - 1; k++) begin
				drain_q[k] <= drain_q[k+1];
			end
		end
	end

	assign ec_out.valid   = drain_cnt_q != '0;
	assign ec_out.ec_byte = drain_q[0];
	assign ec_out.ec_last = drain_cnt_q == CNT_W'(1);

	// The final EC byte leaves the output empty
	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && ec_out.ec_last |=> !ec_out.valid)
		else $error("output still valid after final EC byte");

	// A last byte always starts a drain
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && data_in.last |=> ec_out.valid)
		else $error("no EC output after last byte");

	// No input or config is taken while the generator is rebuilt
	a_build_block: assert property (@(posedge clk) disable iff (!arst_n)
		building |-> !data_in.ready && !cfg.ready)
		else $error("transfer allowed during generator build");

	// A config transfer blocks data on the next cycle
	a_cfg_build: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_xfer |=> !data_in.ready)
		else $error("data accepted right after config");

endmodule
`default_nettype wire

@@ rtl/rsenc_gen_builder.sv @@
// Generator polynomial builder: multiplies in one (x + alpha^i) factor per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rsenc_gen_builder import rsenc_pkg::*; #(
	parameter int MAX_EC_CODEWORDS = MAX_EC_CODEWORDS_DEF,
	parameter int CNT_W            = $clog2(MAX_EC_CODEWORDS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [CNT_W-1:0] n,
	output gf_byte_t              gen [MAX_EC_CODEWORDS],
	output logic                  busy
);

	// poly_q[j] holds the coefficient below the leading 1 at distance j+1
	gf_byte_t         poly_q [MAX_EC_CODEWORDS];
	gf_byte_t         poly_next [MAX_EC_CODEWORDS];
	gf_byte_t         root_q;
	logic [CNT_W-1:0] step_q;
	logic             busy_q;

	// One factor step: each coefficient adds the root times its upper neighbor
	always_comb begin
		for (int j = 0; j < MAX_EC_CODEWORDS; j++) begin
			if (j == 0) begin
				poly_next[j] = poly_q[j] ^ root_q;
			end else begin
				poly_next[j] = poly_q[j] ^ gf_mul(poly_q[j-1], root_q);
			end
		end
	end

	// Sequencer and coefficient registers; reset starts a build for the reset count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			step_q <= '0;
			root_q <= 8'h01;
			for (int j = 0; j < MAX_EC_CODEWORDS; j++) begin
				poly_q[j] <= '0;
			end
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			root_q <= 8'h01;
			for (int j = 0; j < MAX_EC_CODEWORDS; j++) begin
				poly_q[j] <= '0;
			end
		end else if (busy_q) begin
			poly_q <= poly_next;
			root_q <= gf_xtime(root_q);
			step_q <= step_q + CNT_W'(1);
			if (step_q == n - CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign gen  = poly_q;
	assign busy = busy_q;

	// The step counter never passes the degree being built
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q < n)
		else $error("generator step beyond degree");

	// A started build always reports busy on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("build start without busy");

	// The root always starts at one
	a_root_init: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> root_q == 8'h01)
		else $error("root not reset on start");

endmodule
`default_nettype wire
